// ----- sv/lmds_pkg.sv -----
// ----------------------------------------------------------------------------
// lmds_pkg
// Shared types, constants and the digit font for the LED matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lmds_pkg;

    localparam int NUM_DIGITS  = 10;
    localparam int NUM_COLUMNS = 8;
    localparam int DWELL_WIDTH = 16;

    localparam int DIGIT_W  = 4;
    localparam int FRAME_W  = 8;
    localparam int COL_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LATCH_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DWELL_WIDTH;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_DIGIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW_TICKS  = 2'd2;

    localparam logic [DWELL_WIDTH-1:0] DWELL_RESET   = DWELL_WIDTH'(100);
    localparam logic [FRAME_W-1:0]     FRAMES_RESET  = 8'd50;
    localparam logic [LATCH_W-1:0]     LATCH_RESET   = 8'd1;

    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(NUM_DIGITS - 1);
    localparam logic [BYTE_W-1:0]  COL_SELECT = 8'h80;
    localparam logic [BYTE_W-1:0]  BLANK_BYTE = 8'h00;

    typedef enum logic [2:0] {
        PH_DRIVE  = 3'd0,
        PH_SHIFT  = 3'd1,
        PH_LATCH  = 3'd2,
        PH_DWELL  = 3'd3,
        PH_BSHIFT = 3'd4,
        PH_BLATCH = 3'd5
    } t_phase;

    typedef struct packed {
        logic [DIGIT_W-1:0]     digit;
        logic [FRAME_W-1:0]     frame_count;
        logic [COL_W-1:0]       column;
        t_phase                 phase;
        logic [2:0]             bit_count;
        logic                   half_bit;
        logic [BYTE_W-1:0]      shift_word;
        logic [DWELL_WIDTH-1:0] wait_count;
        logic [BYTE_W-1:0]      column_reg;
        logic                   pin_data;
        logic                   pin_sclk;
        logic                   pin_lclk;
    } t_scan_state;

    typedef struct packed {
        logic [DWELL_WIDTH-1:0] dwell_ticks;
        logic [FRAME_W-1:0]     frames_per_digit;
        logic [LATCH_W-1:0]     latch_low_ticks;
    } t_scan_cfg;

    // Column pattern of each digit glyph; digits without a glyph are blank.
    function automatic logic [BYTE_W-1:0] font_byte(input logic [DIGIT_W-1:0] dig,
                                                    input logic [COL_W-1:0] col);
        logic [63:0] row;
        row = 64'h0;
        case (dig)
            4'd0: row = 64'h007E_8181_8181_7E00;
            4'd1: row = 64'h0000_4141_FF01_0100;
            4'd2: row = 64'h0061_8385_8991_6100;
            4'd3: row = 64'h0066_8189_8989_7E00;
            4'd4: row = 64'h1828_4888_7F08_0800;
            4'd5: row = 64'h0000_F989_8989_8F00;
            4'd6: row = 64'h0000_FF89_8989_8F00;
            4'd7: row = 64'h0000_8080_8080_FF00;
            4'd8: row = 64'h0000_FF89_8989_FF00;
            4'd9: row = 64'h0000_F191_9191_FF00;
            default: row = 64'h0;
        endcase
        // Column 0 sits in the top byte.
        return row[(7 - 32'(col)) * BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ----- sv/led_matrix_digit_scanner_core.sv -----
// ----------------------------------------------------------------------------
// led_matrix_digit_scanner_core
// Tick-driven 8x8 LED matrix scanner cycling through the digits.
// ----------------------------------------------------------------------------
// Usage: every input transaction carries one tick (i_run). A tick with run
// high advances the column scan by one step; run low leaves all state as is.
// Each input transaction yields exactly one output transaction carrying the
// column port byte, the serial data, shift clock and latch clock levels, and
// the digit and column being shown, all as they stand after that tick.
// The result of a transaction accepted at one edge is valid from the next
// cycle on. Throughput is one transaction per cycle while the receiver takes
// results; the next-state logic is a single short combinational step that
// feeds the scan state register, which is also the result register.
// o_in_ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result and
// stops new input transactions until it takes it; nothing is dropped.
// Reset (synchronous, active low) restores the default configuration, puts
// the scan at digit 0, column 0, in the column drive phase, with data low
// and both clocks high, and empties the result register.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_digit_scanner_core
    import lmds_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration write port
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    // tick input channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire                    i_run,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [BYTE_W-1:0]      o_column_drive,
    output logic                   o_serial_data,
    output logic                   o_shift_clock,
    output logic                   o_latch_clock,
    output logic [DIGIT_W-1:0]     o_digit_shown,
    output logic [COL_W-1:0]       o_column_index
);

    t_scan_cfg   r_cfg;
    t_scan_state r_state;
    t_scan_state n_state;
    logic        r_out_valid;
    logic        in_take;

    // The result register frees up when it is empty or drained this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    // Configuration registers; writes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dwell_ticks      <= DWELL_RESET;
            r_cfg.frames_per_digit <= FRAMES_RESET;
            r_cfg.latch_low_ticks  <= LATCH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DWELL_TICKS:      r_cfg.dwell_ticks      <= i_cfg_data;
                CFG_FRAMES_PER_DIGIT: r_cfg.frames_per_digit <= i_cfg_data[FRAME_W-1:0];
                CFG_LATCH_LOW_TICKS:  r_cfg.latch_low_ticks  <= i_cfg_data[LATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // One tick of scan logic.
    lmds_scan_step u_step (
        .i_cur (r_state),
        .i_cfg (r_cfg),
        .i_run (i_run),
        .o_nxt (n_state)
    );

    // Scan state. The output fields are taken straight from this register,
    // which only moves when a transaction is accepted, so it doubles as the
    // result register and holds steady while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.digit       <= '0;
            r_state.frame_count <= '0;
            r_state.column      <= '0;
            r_state.phase       <= PH_DRIVE;
            r_state.bit_count   <= '0;
            r_state.half_bit    <= 1'b0;
            r_state.shift_word  <= '0;
            r_state.wait_count  <= '0;
            r_state.column_reg  <= '0;
            r_state.pin_data    <= 1'b0;
            r_state.pin_sclk    <= 1'b1;
            r_state.pin_lclk    <= 1'b1;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_drive = r_state.column_reg;
    assign o_serial_data  = r_state.pin_data;
    assign o_shift_clock  = r_state.pin_sclk;
    assign o_latch_clock  = r_state.pin_lclk;
    assign o_digit_shown  = r_state.digit;
    assign o_column_index = r_state.column;

endmodule

`default_nettype wire

// ----- sv/lmds_scan_step.sv -----
// ----------------------------------------------------------------------------
// lmds_scan_step
// Next-state logic of the scanner for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module lmds_scan_step
    import lmds_pkg::*;
(
    input  wire t_scan_state i_cur,
    input  wire t_scan_cfg   i_cfg,
    input  wire              i_run,
    output t_scan_state      o_nxt
);

    logic [DWELL_WIDTH-1:0] latch_lim;
    logic [DWELL_WIDTH-1:0] dwell_lim;
    logic [FRAME_W-1:0]     frame_lim;
    logic [DWELL_WIDTH-1:0] wc_inc;
    logic                   shift_done;
    logic                   latch_done;
    logic                   dwell_done;
    logic [COL_W-1:0]       col_inc;
    logic [FRAME_W-1:0]     frame_inc;
    logic [DIGIT_W:0]       digit_inc;
    t_phase                 phase_nxt;

    // Zero counts behave as one.
    assign latch_lim = (i_cfg.latch_low_ticks == '0) ? DWELL_WIDTH'(1)
                                                     : DWELL_WIDTH'(i_cfg.latch_low_ticks);
    assign dwell_lim = (i_cfg.dwell_ticks == '0) ? DWELL_WIDTH'(1) : i_cfg.dwell_ticks;
    assign frame_lim = (i_cfg.frames_per_digit == '0) ? FRAME_W'(1) : i_cfg.frames_per_digit;

    assign wc_inc     = i_cur.wait_count + DWELL_WIDTH'(1);
    assign shift_done = i_cur.half_bit && (i_cur.bit_count == 3'd7);
    assign latch_done = (wc_inc >= latch_lim);
    assign dwell_done = (wc_inc >= dwell_lim);
    assign col_inc    = i_cur.column + COL_W'(1);
    assign frame_inc  = i_cur.frame_count + FRAME_W'(1);
    assign digit_inc  = {1'b0, i_cur.digit} + (DIGIT_W+1)'(1);

    // Phase sequencing.
    always_comb begin
        phase_nxt = i_cur.phase;
        unique case (i_cur.phase)
            PH_DRIVE:  phase_nxt = PH_SHIFT;
            PH_SHIFT:  if (shift_done) phase_nxt = PH_LATCH;
            PH_LATCH:  if (latch_done) phase_nxt = PH_DWELL;
            PH_DWELL:  if (dwell_done) phase_nxt = PH_BSHIFT;
            PH_BSHIFT: if (shift_done) phase_nxt = PH_BLATCH;
            default:   if (latch_done) phase_nxt = PH_DRIVE;
        endcase
    end

    // Datapath and pin levels.
    always_comb begin
        o_nxt = i_cur;
        if (i_run) begin
            o_nxt.phase = phase_nxt;
            unique case (i_cur.phase)
                PH_DRIVE: begin
                    o_nxt.column_reg = ~(COL_SELECT >> i_cur.column);
                    o_nxt.pin_lclk   = 1'b1;
                    o_nxt.shift_word = font_byte(i_cur.digit, i_cur.column);
                    o_nxt.bit_count  = '0;
                    o_nxt.half_bit   = 1'b0;
                end
                PH_SHIFT, PH_BSHIFT: begin
                    if (!i_cur.half_bit) begin
                        o_nxt.pin_data   = i_cur.shift_word[BYTE_W-1];
                        o_nxt.shift_word = {i_cur.shift_word[BYTE_W-2:0], 1'b0};
                        o_nxt.pin_sclk   = 1'b0;
                        o_nxt.half_bit   = 1'b1;
                    end else begin
                        o_nxt.pin_sclk  = 1'b1;
                        o_nxt.half_bit  = 1'b0;
                        o_nxt.bit_count = i_cur.bit_count + 3'd1;
                        if (shift_done) begin
                            o_nxt.wait_count = '0;
                        end
                    end
                end
                PH_LATCH: begin
                    o_nxt.pin_lclk   = 1'b0;
                    o_nxt.wait_count = latch_done ? '0 : wc_inc;
                end
                PH_DWELL: begin
                    o_nxt.pin_lclk   = 1'b1;
                    o_nxt.wait_count = dwell_done ? '0 : wc_inc;
                    if (dwell_done) begin
                        o_nxt.shift_word = BLANK_BYTE;
                        o_nxt.bit_count  = '0;
                        o_nxt.half_bit   = 1'b0;
                    end
                end
                default: begin
                    // Blank latch; the last tick moves on to the next column.
                    o_nxt.pin_lclk   = 1'b0;
                    o_nxt.wait_count = latch_done ? '0 : wc_inc;
                    if (latch_done) begin
                        o_nxt.column = col_inc;
                        if (col_inc == '0) begin
                            if (frame_inc >= frame_lim) begin
                                o_nxt.frame_count = '0;
                                o_nxt.digit = (digit_inc >= (DIGIT_W+1)'(NUM_DIGITS)) ? '0
                                              : digit_inc[DIGIT_W-1:0];
                            end else begin
                                o_nxt.frame_count = frame_inc;
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire
